// ----- rtl/mdrc_pkg.sv -----
// Shared constants, types and helpers for the motor duty ramp controller.
package mdrc_pkg;

    localparam int POS_W     = 16;
    localparam int DUTY_W    = 15;
    localparam int CMP_W     = 14;
    localparam int STEP_W    = 14;
    localparam int DIR_W     = 2;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam int FULL_DUTY    = 10000;
    localparam int SPEED_MAX_CM = 50;
    localparam int SPEED_MIN_CM = 3;
    localparam int DUTY_PER_CM  = 200;
    localparam int STEP_RESET   = 200;

    // Byte address of the step register
    localparam logic [PADDR_W-1:0] ADDR_MAX_DUTY_CHANGE = PADDR_W'(0);

    typedef enum logic [DIR_W-1:0] {
        DIR_HOLD      = 2'd0,
        DIR_UP        = 2'd1,
        DIR_DOWN      = 2'd2,
        DIR_AT_TARGET = 2'd3
    } dir_t;

    // Distance cap: clamp distance to the speed window, scale, limit to full duty.
    function automatic logic [CMP_W-1:0] distance_cap(input logic [POS_W:0] span);
        logic [5:0]  clamped;
        logic [CMP_W:0] scaled;
        begin
            if (span > (POS_W+1)'(SPEED_MAX_CM))
                clamped = 6'(SPEED_MAX_CM);
            else if (span < (POS_W+1)'(SPEED_MIN_CM))
                clamped = 6'(SPEED_MIN_CM);
            else
                clamped = span[5:0];
            scaled = (CMP_W+1)'(clamped) * (CMP_W+1)'(DUTY_PER_CM);
            if (scaled > (CMP_W+1)'(FULL_DUTY))
                scaled = (CMP_W+1)'(FULL_DUTY);
            distance_cap = scaled[CMP_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/mdrc_if.sv -----
// Valid/ready channel interfaces for control ticks and PWM results.
interface mdrc_tick_if;
    logic                                valid;
    logic                                ready;
    logic signed [mdrc_pkg::POS_W-1:0]   current_position;
    logic signed [mdrc_pkg::POS_W-1:0]   target_position;
    logic                                stop_request;

    modport source (output valid, current_position, target_position, stop_request,
                    input ready);
    modport sink   (input valid, current_position, target_position, stop_request,
                    output ready);
endinterface

interface mdrc_pwm_if;
    logic                          valid;
    logic                          ready;
    logic [mdrc_pkg::CMP_W-1:0]    up_compare;
    logic [mdrc_pkg::CMP_W-1:0]    down_compare;
    logic [mdrc_pkg::DIR_W-1:0]    direction_code;

    modport source (output valid, up_compare, down_compare, direction_code,
                    input ready);
    modport sink   (input valid, up_compare, down_compare, direction_code,
                    output ready);
endinterface

// ----- rtl/motor_duty_ramp_controller.sv -----
// Top level: trapezoidal duty ramp with PWM compare outputs and APB step register.
// Result: an accepted tick item's outputs are captured in the result register.
// Throughput: one item per cycle unless a pending result is stalled by pwm.ready;
//   the single duty register updates at each accepted tick.
// Input is taken whenever the result register is empty or being drained in the same cycle.
// Reset (rst_n low, asynchronous): duty cleared to zero, max_duty_change set to 200,
//   no result pending.
module motor_duty_ramp_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdrc_pkg::PADDR_W-1:0]        paddr,
    input  logic [mdrc_pkg::PDATA_W-1:0]        pwdata,
    output logic [mdrc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    mdrc_tick_if.sink                           tick,
    mdrc_pwm_if.source                          pwm
);

    // Widened arithmetic so that duty +/- step never wraps
    localparam int AW = mdrc_pkg::DUTY_W + 2;

    logic [mdrc_pkg::STEP_W-1:0]        step_reg;
    logic signed [mdrc_pkg::DUTY_W-1:0] duty_reg;
    logic signed [mdrc_pkg::DUTY_W-1:0] duty_next;

    logic                               out_valid_reg;
    logic [mdrc_pkg::CMP_W-1:0]         up_reg;
    logic [mdrc_pkg::CMP_W-1:0]         down_reg;
    mdrc_pkg::dir_t                     dir_reg;
    mdrc_pkg::dir_t                     dir_next;

    logic                               cfg_write;
    logic                               tick_fire;

    logic signed [mdrc_pkg::POS_W:0]    pos_ext;
    logic signed [mdrc_pkg::POS_W:0]    tgt_ext;
    logic                               move_up;
    logic                               move_down;
    logic [mdrc_pkg::POS_W:0]           span;
    logic [mdrc_pkg::CMP_W-1:0]         cap;
    logic signed [AW-1:0]               duty_ext;
    logic signed [AW-1:0]               step_ext;
    logic signed [AW-1:0]               cap_ext;
    logic signed [AW-1:0]               accel;
    logic signed [AW-1:0]               limited;
    logic signed [AW-1:0]               duty_wide;
    logic [mdrc_pkg::DUTY_W-1:0]        duty_mag;

    // ---------------------------------------------------------------
    // Configuration port: single step register, writes complete in access phase
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= mdrc_pkg::STEP_W'(mdrc_pkg::STEP_RESET);
        else if (cfg_write && paddr == mdrc_pkg::ADDR_MAX_DUTY_CHANGE)
            step_reg <= pwdata[mdrc_pkg::STEP_W-1:0];
    end

    always_comb
    begin
        if (paddr == mdrc_pkg::ADDR_MAX_DUTY_CHANGE)
            prdata = mdrc_pkg::PDATA_W'(step_reg);
        else
            prdata = '0;
    end

    // ---------------------------------------------------------------
    // Handshake: the result register frees up when it is empty or being taken
    // ---------------------------------------------------------------
    assign tick.ready = !out_valid_reg || pwm.ready;
    assign tick_fire  = tick.valid && tick.ready;

    // ---------------------------------------------------------------
    // Duty update
    // ---------------------------------------------------------------
    assign pos_ext   = (mdrc_pkg::POS_W+1)'(tick.current_position);
    assign tgt_ext   = (mdrc_pkg::POS_W+1)'(tick.target_position);
    assign move_up   = tgt_ext > pos_ext;
    assign move_down = tgt_ext < pos_ext;

    // Distance to go, always non-negative when moving
    assign span = move_up ? (mdrc_pkg::POS_W+1)'(tgt_ext - pos_ext)
                          : (mdrc_pkg::POS_W+1)'(pos_ext - tgt_ext);
    assign cap  = mdrc_pkg::distance_cap(span);

    assign duty_ext = AW'(duty_reg);
    assign step_ext = AW'(step_reg);
    assign cap_ext  = AW'(cap);

    // Accelerate in the wanted direction from the current duty
    assign accel   = move_up ? (duty_ext + step_ext) : (step_ext - duty_ext);
    assign limited = (cap_ext < accel) ? cap_ext : accel;

    always_comb
    begin
        duty_wide = '0;
        dir_next  = mdrc_pkg::DIR_AT_TARGET;
        if (tick.stop_request)
        begin
            // Ramp toward zero, snap once within one step
            dir_next = mdrc_pkg::DIR_HOLD;
            if (duty_ext >= step_ext)
                duty_wide = duty_ext - step_ext;
            else if (duty_ext <= -step_ext)
                duty_wide = duty_ext + step_ext;
            else
                duty_wide = '0;
        end
        else if (move_up)
        begin
            dir_next  = mdrc_pkg::DIR_UP;
            duty_wide = limited;
        end
        else if (move_down)
        begin
            dir_next  = mdrc_pkg::DIR_DOWN;
            duty_wide = -limited;
        end
    end

    // Magnitude stays within full duty, so the low bits hold the whole value
    assign duty_next = duty_wide[mdrc_pkg::DUTY_W-1:0];
    assign duty_mag  = duty_next[mdrc_pkg::DUTY_W-1] ? mdrc_pkg::DUTY_W'(-duty_next)
                                                     : mdrc_pkg::DUTY_W'(duty_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= '0;
        else if (tick_fire)
            duty_reg <= duty_next;
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_fire)
            out_valid_reg <= 1'b1;
        else if (pwm.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            if (duty_next[mdrc_pkg::DUTY_W-1])
            begin
                up_reg   <= '0;
                down_reg <= duty_mag[mdrc_pkg::CMP_W-1:0];
            end
            else
            begin
                up_reg   <= duty_mag[mdrc_pkg::CMP_W-1:0];
                down_reg <= '0;
            end
            dir_reg <= dir_next;
        end
    end

    assign pwm.valid          = out_valid_reg;
    assign pwm.up_compare     = up_reg;
    assign pwm.down_compare   = down_reg;
    assign pwm.direction_code = dir_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_duty_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_reg <= mdrc_pkg::DUTY_W'(mdrc_pkg::FULL_DUTY)) &&
        (duty_reg >= -(mdrc_pkg::DUTY_W'(mdrc_pkg::FULL_DUTY))))
        else $error("duty left the full-duty window");

    a_one_side_driven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (up_reg == '0 || down_reg == '0))
        else $error("both PWM compare values non-zero");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_fire && !tick.stop_request &&
         tick.current_position == tick.target_position)
        |=> (duty_reg == '0 && up_reg == '0 && down_reg == '0))
        else $error("duty not zero at target");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> out_valid_reg)
        else $error("accepted tick produced no result");

endmodule
